// ===== rtl/tree_path_cost_binary_lifting_core_assert.svh =====
// assertion macros for the path cost core
`ifndef TREE_PATH_COST_BINARY_LIFTING_CORE_ASSERT_SVH
`define TREE_PATH_COST_BINARY_LIFTING_CORE_ASSERT_SVH

// implication checked on every edge outside reset
`define TPC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tpc_pkg.sv =====
`default_nettype none
package tpc_pkg;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_LOAD  = 2'd1;
   localparam logic [1:0] ST_BAD_QUERY = 2'd2;
   localparam logic [1:0] ST_RELOADED  = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_LOAD_RD,
      S_LOAD_WR,
      S_Q_DEPTH,
      S_LIFT_RD,
      S_LIFT_STEP,
      S_JUMP_RD,
      S_JUMP_STEP,
      S_FINAL_RD,
      S_FINAL,
      S_DONE
   } state_type;

   // controller commands to the datapath
   typedef struct packed {
      logic clear;       // clear one loaded flag
      logic latch;       // capture request fields
      logic chk;         // capture status of the request checks
      logic load_init;   // write level 0 row and depth
      logic load_rd;     // read mid row for current level
      logic load_wr;     // write next level (level counter plus one)
      logic depth_rd;    // read both depths
      logic order;       // order so that y is deeper
      logic pair_rd;     // read rows of x and y at level
      logic lift_step;   // apply lift at level
      logic jump_step;   // apply jump at level
      logic final_step;  // add level 0 costs
      logic lvl_clear;   // level counter to 0
      logic lvl_top;     // level counter to LEVELS-1
      logic lvl_inc;
      logic lvl_dec;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;  // last loaded flag being cleared
      logic       is_query;
      logic [1:0] check;   // status of the request checks
      logic       lvl_last;
      logic       lvl_zero;
      logic       same;    // x equals y after lift
   } stat_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/tpc_ctrl.sv =====
`default_nettype none
module tpc_ctrl import tpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output logic          busy,
   output logic          done,
   output cmd_type       cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != S_IDLE);
      done = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.chk = 1'b1;
            if (stat.check != ST_OK) begin
               state_in = S_DONE;
            end else if (stat.is_query) begin
               cmd.depth_rd = 1'b1;
               state_in = S_Q_DEPTH;
            end else begin
               cmd.load_init = 1'b1;
               cmd.lvl_clear = 1'b1;
               state_in = S_LOAD_RD;
            end
         end
         S_LOAD_RD: begin
            if (stat.lvl_last) begin
               state_in = S_DONE;
            end else begin
               cmd.load_rd = 1'b1;
               state_in = S_LOAD_WR;
            end
         end
         S_LOAD_WR: begin
            cmd.load_wr = 1'b1;
            cmd.lvl_inc = 1'b1;
            state_in = S_LOAD_RD;
         end
         S_Q_DEPTH: begin
            cmd.order = 1'b1;
            cmd.lvl_clear = 1'b1;
            state_in = S_LIFT_RD;
         end
         S_LIFT_RD: begin
            cmd.pair_rd = 1'b1;
            state_in = S_LIFT_STEP;
         end
         S_LIFT_STEP: begin
            cmd.lift_step = 1'b1;
            if (stat.lvl_last) begin
               cmd.lvl_top = 1'b1;
               state_in = S_JUMP_RD;
            end else begin
               cmd.lvl_inc = 1'b1;
               state_in = S_LIFT_RD;
            end
         end
         S_JUMP_RD: begin
            if (stat.same) begin
               state_in = S_DONE;
            end else begin
               cmd.pair_rd = 1'b1;
               state_in = S_JUMP_STEP;
            end
         end
         S_JUMP_STEP: begin
            cmd.jump_step = 1'b1;
            if (stat.lvl_zero) begin
               state_in = S_FINAL_RD;
            end else begin
               cmd.lvl_dec = 1'b1;
               state_in = S_JUMP_RD;
            end
         end
         S_FINAL_RD: begin
            cmd.pair_rd = 1'b1;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            cmd.final_step = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/tpc_datapath.sv =====
`default_nettype none
module tpc_datapath import tpc_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic        req_op,
   input  wire logic [9:0]  req_node_id,
   input  wire logic [9:0]  req_parent_node,
   input  wire logic [15:0] req_edge_weight,
   input  wire logic [9:0]  req_other_node,
   output stat_type         stat,
   output logic [1:0]       status,
   output logic [31:0]      path_cost,
   output logic [9:0]       ancestor_node
);
   localparam int LW    = $clog2(LEVELS);
   localparam int NW    = $clog2(MAX_NODES);
   localparam int DEPTH = MAX_NODES * LEVELS;
   localparam int AW    = $clog2(DEPTH);

   // jump rows, addressed node*LEVELS+level; node 0 rows are never written
   logic [9:0]  anc_mem  [DEPTH];
   logic [31:0] cost_mem [DEPTH];
   logic [9:0]  depth_mem [MAX_NODES];
   logic        loaded_mem [MAX_NODES];

   logic        op_ff;
   logic [9:0]  a_ff, p_ff, b_ff;
   logic [15:0] w_ff;
   logic [9:0]  x_ff, y_ff;
   logic [31:0] sum_ff;
   logic [LW-1:0] lvl_ff;
   logic [9:0]  prev_anc_ff;   // this node's row at level-1
   logic [31:0] prev_cost_ff;
   logic [9:0]  da_ff, db_ff;
   logic [9:0]  rxa_ff, rya_ff;
   logic [31:0] rxc_ff, ryc_ff;
   logic [1:0]  st_ff;
   logic        same_ff;
   logic        la_ff, lo_ff;  // loaded flags of node_id and of parent or other node
   logic [9:0]  dp_ff;         // depth of the parent
   logic [NW-1:0] clr_ff;

   function automatic logic in_range(input logic [9:0] v);
      in_range = ({22'd0, v} < 32'(MAX_NODES));
   endfunction

   function automatic logic usable(input logic [9:0] v, input logic ld);
      usable = (v != '0) && in_range(v) && ld;
   endfunction

   function automatic logic [AW-1:0] row(input logic [9:0] n, input logic [LW-1:0] l);
      row = AW'(n[NW-1:0] * LEVELS + l);
   endfunction

   logic [1:0] check;
   always_comb begin
      if (op_ff) begin
         check = (usable(a_ff, la_ff) && usable(b_ff, lo_ff)) ? ST_OK : ST_BAD_QUERY;
      end else if (a_ff == '0 || !in_range(a_ff)) begin
         check = ST_BAD_LOAD;
      end else if (la_ff) begin
         check = ST_RELOADED;
      end else if (p_ff != '0 && !usable(p_ff, lo_ff)) begin
         check = ST_BAD_LOAD;
      end else begin
         check = ST_OK;
      end
   end

   logic [9:0] rd_node_a, rd_node_b;
   logic [LW-1:0] rd_lvl;
   always_comb begin
      rd_node_a = x_ff;
      rd_node_b = y_ff;
      rd_lvl = lvl_ff;
      if (cmd.load_rd) begin
         rd_node_a = prev_anc_ff;
         rd_lvl = LW'(lvl_ff);
      end
   end

   logic [LW-1:0] lvl_p1;
   assign lvl_p1 = LW'(lvl_ff + 1'b1);

   logic [9:0] diff;
   assign diff = db_ff - da_ff;

   logic [9:0]  wr_anc;
   logic [31:0] wr_cost;
   assign wr_anc  = (prev_anc_ff == '0) ? '0 : rxa_ff;
   assign wr_cost = sat_add(prev_cost_ff, (prev_anc_ff == '0) ? 32'd0 : rxc_ff);

   // clearing pass over the loaded flags after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= NW'(clr_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         loaded_mem[clr_ff] <= 1'b0;
      end else if (cmd.load_init) begin
         loaded_mem[a_ff[NW-1:0]] <= 1'b1;
      end
      if (cmd.latch) begin
         la_ff <= loaded_mem[req_node_id[NW-1:0]];
         lo_ff <= loaded_mem[req_op ? req_other_node[NW-1:0] : req_parent_node[NW-1:0]];
         dp_ff <= depth_mem[req_parent_node[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_op;
         a_ff  <= req_node_id;
         p_ff  <= req_parent_node;
         w_ff  <= req_edge_weight;
         b_ff  <= req_other_node;
         sum_ff <= '0;
         x_ff <= '0;
         same_ff <= 1'b0;
      end
      if (cmd.chk) begin
         st_ff <= check;
      end
      if (cmd.load_init) begin
         anc_mem[row(a_ff, '0)]  <= p_ff;
         cost_mem[row(a_ff, '0)] <= (p_ff == '0) ? 32'd0 : {16'd0, w_ff};
         depth_mem[a_ff[NW-1:0]] <= ((p_ff == '0) ? 10'd0 : dp_ff) + 10'd1;
         prev_anc_ff  <= p_ff;
         prev_cost_ff <= (p_ff == '0) ? 32'd0 : {16'd0, w_ff};
      end
      if (cmd.load_rd || cmd.pair_rd) begin
         rxa_ff <= anc_mem[row(rd_node_a, rd_lvl)];
         rxc_ff <= cost_mem[row(rd_node_a, rd_lvl)];
         rya_ff <= anc_mem[row(rd_node_b, rd_lvl)];
         ryc_ff <= cost_mem[row(rd_node_b, rd_lvl)];
      end
      if (cmd.load_wr) begin
         anc_mem[row(a_ff, lvl_p1)]  <= wr_anc;
         cost_mem[row(a_ff, lvl_p1)] <= wr_cost;
         prev_anc_ff  <= wr_anc;
         prev_cost_ff <= wr_cost;
      end
      if (cmd.depth_rd) begin
         da_ff <= depth_mem[a_ff[NW-1:0]];
         db_ff <= depth_mem[b_ff[NW-1:0]];
      end
      if (cmd.order) begin
         if (da_ff > db_ff) begin
            x_ff <= b_ff; y_ff <= a_ff;
            da_ff <= db_ff; db_ff <= da_ff;
         end else begin
            x_ff <= a_ff; y_ff <= b_ff;
         end
      end
      if (cmd.lift_step) begin
         if (diff[lvl_ff]) begin
            sum_ff <= sat_add(sum_ff, ryc_ff);
            y_ff   <= rya_ff;
            same_ff <= (x_ff == rya_ff);
         end else begin
            same_ff <= (x_ff == y_ff);
         end
      end
      if (cmd.jump_step && rxa_ff != rya_ff) begin
         sum_ff <= sat_add(sat_add(sum_ff, rxc_ff), ryc_ff);
         x_ff <= rxa_ff;
         y_ff <= rya_ff;
      end
      if (cmd.final_step) begin
         sum_ff <= sat_add(sat_add(sum_ff, rxc_ff), ryc_ff);
         x_ff <= rxa_ff;
      end
      if (cmd.lvl_clear) begin
         lvl_ff <= '0;
      end else if (cmd.lvl_top) begin
         lvl_ff <= LW'(LEVELS - 1);
      end else if (cmd.lvl_inc) begin
         lvl_ff <= lvl_p1;
      end else if (cmd.lvl_dec) begin
         lvl_ff <= LW'(lvl_ff - 1'b1);
      end
   end

   // x stays correct when lift ends equal: x holds the ancestor
   assign stat.clr_last = (clr_ff == NW'(MAX_NODES - 1));
   assign stat.is_query = op_ff;
   assign stat.check    = check;
   assign stat.lvl_last = (lvl_ff == LW'(LEVELS - 1));
   assign stat.lvl_zero = (lvl_ff == '0);
   assign stat.same     = same_ff;

   assign status        = st_ff;
   assign path_cost     = (st_ff == ST_OK && op_ff) ? sum_ff : 32'd0;
   assign ancestor_node = (st_ff == ST_OK && op_ff) ? x_ff : 10'd0;
endmodule
`default_nettype wire

// ===== rtl/tree_path_cost_binary_lifting_core.sv =====
`default_nettype none
// path cost and lowest common ancestor over a loaded tree by binary lifting.
// start is taken while busy is low; every item gives one result on the rsp_
// ports for a single cycle, flagged by rsp_valid, which the receiver must take
// as it comes. after reset busy stays high while the loaded flags are cleared
// one per cycle. a load walks the jump table one level at a time. a query lifts
// over LEVELS levels and finishes there when the lift already meets, else it
// jumps back over them one level at a time and then adds the level 0 costs.
// each level costs one read of each table per node. rejected items finish
// straight after the request checks.
module tree_path_cost_binary_lifting_core import tpc_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [9:0]  req_node_id,
   input  wire logic [9:0]  req_parent_node,
   input  wire logic [15:0] req_edge_weight,
   input  wire logic [9:0]  req_other_node,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_path_cost,
   output logic [9:0]       rsp_ancestor_node
);
   `include "tree_path_cost_binary_lifting_core_assert.svh"

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   tpc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .busy(busy), .done(rsp_valid), .cmd(cmd)
   );

   // tables and arithmetic
   tpc_datapath #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_op(req_op), .req_node_id(req_node_id), .req_parent_node(req_parent_node),
      .req_edge_weight(req_edge_weight), .req_other_node(req_other_node),
      .stat(stat), .status(rsp_status), .path_cost(rsp_path_cost),
      .ancestor_node(rsp_ancestor_node)
   );

   `TPC_ASSERT_NEXT(a_valid_single, clock, reset, rsp_valid, !rsp_valid, "result repeated")
   `TPC_ASSERT_IMPLY(a_valid_busy, clock, reset, rsp_valid, busy, "result while idle")
   `TPC_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_path_cost == 32'd0 && rsp_ancestor_node == 10'd0, "failed item with payload")
endmodule
`default_nettype wire
